>>> hdl/bts_pkg.sv
`default_nettype none
package bts_pkg;

    localparam int BYTE_W      = 8;
    localparam int KEY_ENTRY_W = 4;
    localparam int KEY_ENTRIES = 16;
    localparam int KEY_W       = KEY_ENTRY_W * KEY_ENTRIES;
    localparam int BLEN_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = KEY_W;
    localparam int CMP_W       = KEY_ENTRY_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERMUTATION_KEY = 2'd2;

    localparam logic              MODE_RESET = 1'b1;
    localparam logic [BLEN_W-1:0] BLEN_RESET = 5'd8;

    typedef enum logic {
        ST_FILL  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

endpackage
`default_nettype wire

>>> hdl/block_transposition_cipher.sv
// Block transposition cipher.
// Input channel (s_valid/s_ready, s_data_byte): one byte per transaction. Bytes
// fill a block of block_length bytes; each byte is written into a MAX_BLOCK-entry
// slot memory at its permuted position (encrypt: key entry of its position;
// decrypt: last position whose key entry names it, else slot 0).
// Output channel (m_valid/m_ready): when a block completes, its slots are read
// out of the memory in order, one transaction per cycle while m_ready is high,
// m_block_last on the final slot and m_key_error on all slots if any key entry
// used was out of range. A block is taken in full before it is emitted;
// s_ready is low while a block is being emitted. The first result is
// presented the cycle after the completing byte is accepted (the slot memory
// read is registered, covered by reading slot 0 during the fill).
// When m_ready is low the current slot is held and the read address stays put.
// Slots not written in a block read as zero through per-slot valid bits that
// are cleared at every block start.
// Reset: mode encrypt, block_length 8, key zero, fill count zero, no output.
// Configuration writes (cfg_wr_en/cfg_index/cfg_wr_data) take effect at once
// and are expected only while the block is idle.
`default_nettype none
module block_transposition_cipher
    import bts_pkg::*;
#(
    parameter int MAX_BLOCK = 16
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]   cfg_index,
    input  wire  [CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire  [BYTE_W-1:0]      s_data_byte,
    output logic                   m_valid,
    input  wire                    m_ready,
    output logic [BYTE_W-1:0]      m_out_byte,
    output logic                   m_block_last,
    output logic                   m_key_error
);

    localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int LEN_W = $clog2(MAX_BLOCK + 1);

    // configuration
    logic              mode_reg;
    logic [BLEN_W-1:0] blen_reg;
    logic [KEY_W-1:0]  key_reg;

    // control
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   fill_reg, fill_next;
    logic               err_reg, err_next;
    logic [MAX_BLOCK-1:0] slot_vld_reg, slot_vld_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   last_reg, last_next;

    // slot memory and its read port
    logic [BYTE_W-1:0]  mem [MAX_BLOCK];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic [LEN_W-1:0]       eff_len;
    logic [KEY_ENTRY_W-1:0] key_k;
    logic                   key_bad;
    logic [IDX_W-1:0]       dec_dest;
    logic                   in_xact, out_xact, blk_done;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
            blen_reg <= BLEN_RESET;
            key_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CIPHER_MODE:     mode_reg <= cfg_wr_data[0];
                CFG_BLOCK_LENGTH:    blen_reg <= cfg_wr_data[BLEN_W-1:0];
                CFG_PERMUTATION_KEY: key_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (blen_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (blen_reg > BLEN_W'(MAX_BLOCK)) begin
            eff_len = LEN_W'(MAX_BLOCK);
        end else begin
            eff_len = LEN_W'(blen_reg);
        end
    end

    assign key_k   = key_reg[fill_reg*KEY_ENTRY_W +: KEY_ENTRY_W];
    assign key_bad = CMP_W'(key_k) >= CMP_W'(eff_len);

    // inverse permutation: last position below the length whose entry names fill_reg
    always_comb begin
        dec_dest = '0;
        for (int i = 0; i < MAX_BLOCK; i++) begin
            if ((CMP_W'(i) < CMP_W'(eff_len)) &&
                (CMP_W'(key_reg[i*KEY_ENTRY_W +: KEY_ENTRY_W]) == CMP_W'(fill_reg))) begin
                dec_dest = IDX_W'(i);
            end
        end
    end

    assign in_xact  = s_valid && s_ready;
    assign out_xact = m_valid && m_ready;
    assign blk_done = (CMP_W'(fill_reg) + CMP_W'(1)) >= CMP_W'(eff_len);
    assign wr_en    = in_xact && (!mode_reg || !key_bad);
    assign wr_addr  = mode_reg ? IDX_W'(key_k) : dec_dest;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL: begin
                if (in_xact && blk_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_xact && m_block_last) begin
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        fill_next     = fill_reg;
        err_next      = err_reg;
        slot_vld_next = slot_vld_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        rd_addr       = '0;
        case (state_reg)
            ST_FILL: begin
                s_ready = 1'b1;
                if (in_xact) begin
                    if (fill_reg == '0) begin
                        slot_vld_next = '0;
                        err_next      = 1'b0;
                    end
                    if (wr_en) begin
                        slot_vld_next[wr_addr] = 1'b1;
                    end
                    err_next  = err_next | key_bad;
                    fill_next = blk_done ? '0 : fill_reg + IDX_W'(1);
                    last_next = IDX_W'(eff_len - LEN_W'(1));
                    idx_next  = '0;
                end
            end
            ST_DRAIN: begin
                m_valid = 1'b1;
                rd_addr = idx_reg;
                if (out_xact) begin
                    if (m_block_last) begin
                        idx_next = '0;
                        rd_addr  = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_addr  = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_out_byte   = rd_vld_reg ? rd_data_reg : '0;
    assign m_block_last = (idx_reg == last_reg);
    assign m_key_error  = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            fill_reg     <= '0;
            err_reg      <= 1'b0;
            slot_vld_reg <= '0;
            idx_reg      <= '0;
            last_reg     <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            err_reg      <= err_next;
            slot_vld_reg <= slot_vld_next;
            idx_reg      <= idx_next;
            last_reg     <= last_next;
            rd_vld_reg   <= slot_vld_next[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_data_byte;
        end
    end

    // forward a same-cycle write to the read port
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= s_data_byte;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a block is being emitted");

    a_last_ends_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xact && m_block_last) |=> (!m_valid && s_ready))
        else $error("output still valid after last transaction");

    a_err_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_xact && !m_block_last) |=> (m_key_error == $past(m_key_error)))
        else $error("key_error changed within a block");

    a_fill_starts_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xact && blk_done) |=> (m_valid && (idx_reg == '0) && (fill_reg == '0)))
        else $error("completed block not presented from slot zero");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (idx_reg <= last_reg))
        else $error("read index beyond block length");
`endif

endmodule
`default_nettype wire
